@@ sv/vn_pkg.sv @@
// Shared constants and types for the vector normalize unit.
package vn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COMP_W    = 32;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int LEN_W     = 32;
  localparam int MIN_W     = 17;
  localparam int SQ_STEPS  = LEN_W;
  localparam int REM_W     = LEN_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DIV_STEPS = QUO_W;

  // side data that rides along the root and divide stages
  typedef struct packed {
    logic [OUT_W-1:0] rx;
    logic [OUT_W-1:0] ry;
    logic [OUT_W-1:0] rz;
    logic             sx;
    logic             sy;
    logic             sz;
    logic             two_d;
  } side_t;

endpackage

@@ sv/vn_div_lane.sv @@
// One divide lane: magnitude * 2^FRAC_BITS / length, one quotient bit per stage.
module vn_div_lane
  import vn_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [COMP_W-1:0] mag,
  input  logic [LEN_W-1:0]  len,
  output logic [QUO_W-1:0]  quo
);

  logic [REM_W-1:0] rem [0:DIV_STEPS];
  logic [LEN_W-1:0] dsr [0:DIV_STEPS];
  logic [QUO_W-1:0] q   [0:DIV_STEPS];

  // magnitude never exceeds the length, so the first step yields the top bit
  assign rem[0] = {1'b0, mag};
  assign dsr[0] = len;
  assign q[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             ge;
    logic [REM_W-1:0] diff;
    assign ge   = rem[k] >= {1'b0, dsr[k]};
    assign diff = ge ? (rem[k] - {1'b0, dsr[k]}) : rem[k];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= {diff[REM_W-2:0], 1'b0};
        dsr[k+1] <= dsr[k];
        q[k+1]   <= {q[k][QUO_W-2:0], ge};
      end
    end
  end

  assign quo = q[DIV_STEPS];

endmodule

@@ sv/vector_normalize_unit.sv @@
// Top level of the vector normalize unit: length and unit vector of a 2D/3D vector.
//
// Accepts one vector per cycle while the output side does not stall and
// returns one result beat per vector, in order, from the output register.
// Stages A to C (magnitudes, squares, sum) feed the bit-serial square root (one
// root bit per stage, 32 stages) followed by three parallel divide lanes (one
// quotient bit per stage, FRAC_BITS + 1 stages). The whole pipeline advances
// together whenever the output register is empty or being drained, so
// s_tready follows m_tready and back-pressure holds every stage in place.
// The length is floor(sqrt(x^2 + y^2 + z^2)) in Q16.16; each component is
// divided by it into Q2.16. If the length is at or below min_length the low
// 18 bits of the inputs pass through and too_short is set; in 2D mode z_out
// is always zero. min_length is written through the cfg channel, which is
// always ready, and should only change while no vector is in flight.
module vector_normalize_unit
  import vn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [3*COMP_W-1:0]    s_tdata,   // x_in, y_in, z_in
  input  logic                   s_tuser,   // is_2d
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [3*OUT_W+LEN_W+1:0] m_tdata, // x_out, y_out, z_out, vec_length, pad
  output logic                   m_tuser,   // too_short
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MIN_W-1:0]       cfg_data   // min_length
);

  logic             en;
  logic [MIN_W-1:0] min_length;

  // advance everything when the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  // ---- stage A: magnitudes ----
  logic [COMP_W-1:0] cx, cy, cz;
  logic              a_v;
  logic [COMP_W:0]   a_mx, a_my, a_mz;
  side_t             a_sd;

  assign cx = s_tdata[COMP_W-1:0];
  assign cy = s_tdata[2*COMP_W-1:COMP_W];
  assign cz = s_tdata[3*COMP_W-1:2*COMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mx <= cx[COMP_W-1] ? ({1'b0, ~cx} + 1'b1) : {1'b0, cx};
      a_my <= cy[COMP_W-1] ? ({1'b0, ~cy} + 1'b1) : {1'b0, cy};
      // drop z from the length in 2D mode
      a_mz <= s_tuser ? '0 : (cz[COMP_W-1] ? ({1'b0, ~cz} + 1'b1) : {1'b0, cz});
      a_sd <= '{rx: cx[OUT_W-1:0], ry: cy[OUT_W-1:0], rz: cz[OUT_W-1:0],
                sx: cx[COMP_W-1], sy: cy[COMP_W-1], sz: cz[COMP_W-1],
                two_d: s_tuser};
    end
  end

  // ---- stage B: squares (32x32 each, magnitude at most 2^31) ----
  logic              b_v;
  logic [63:0]       b_qx, b_qy, b_qz;
  logic [COMP_W-1:0] b_mx, b_my, b_mz;
  side_t             b_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_qx <= 64'(a_mx) * 64'(a_mx);
      b_qy <= 64'(a_my) * 64'(a_my);
      b_qz <= 64'(a_mz) * 64'(a_mz);
      b_mx <= a_mx[COMP_W-1:0] | {a_mx[COMP_W], {(COMP_W-1){1'b0}}};
      b_my <= a_my[COMP_W-1:0] | {a_my[COMP_W], {(COMP_W-1){1'b0}}};
      b_mz <= a_mz[COMP_W-1:0] | {a_mz[COMP_W], {(COMP_W-1){1'b0}}};
      b_sd <= a_sd;
    end
  end

  // ---- stage C: sum of squares, fits 64 bits ----
  logic              c_v;
  logic [63:0]       c_sum;
  logic [COMP_W-1:0] c_mx, c_my, c_mz;
  side_t             c_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum <= b_qx + b_qy + b_qz;
      c_mx  <= b_mx;
      c_my  <= b_my;
      c_mz  <= b_mz;
      c_sd  <= b_sd;
    end
  end

  // ---- square root: one root bit per stage ----
  logic              r_v    [0:SQ_STEPS];
  logic [63:0]       r_n    [0:SQ_STEPS];
  logic [REM_W-1:0]  r_rem  [0:SQ_STEPS];
  logic [LEN_W-1:0]  r_root [0:SQ_STEPS];
  logic [COMP_W-1:0] r_mx   [0:SQ_STEPS];
  logic [COMP_W-1:0] r_my   [0:SQ_STEPS];
  logic [COMP_W-1:0] r_mz   [0:SQ_STEPS];
  side_t             r_sd   [0:SQ_STEPS];

  assign r_v[0]    = c_v;
  assign r_n[0]    = c_sum;
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_mx[0]   = c_mx;
  assign r_my[0]   = c_my;
  assign r_mz[0]   = c_mz;
  assign r_sd[0]   = c_sd;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] pr;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W+1:0] diff;
    assign pr    = {r_rem[k], r_n[k][63:62]};
    assign trial = {1'b0, r_root[k], 2'b01};
    assign ge    = pr >= trial;
    assign diff  = ge ? (pr - trial) : pr;

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v[k+1] <= 1'b0;
      end else if (en) begin
        r_v[k+1] <= r_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_n[k+1]    <= {r_n[k][61:0], 2'b00};
        r_rem[k+1]  <= diff[REM_W-1:0];
        r_root[k+1] <= {r_root[k][LEN_W-2:0], ge};
        r_mx[k+1]   <= r_mx[k];
        r_my[k+1]   <= r_my[k];
        r_mz[k+1]   <= r_mz[k];
        r_sd[k+1]   <= r_sd[k];
      end
    end
  end

  // ---- divide lanes, side data keeps pace ----
  logic [QUO_W-1:0] qx, qy, qz;
  logic             d_v   [0:DIV_STEPS];
  logic [LEN_W-1:0] d_len [0:DIV_STEPS];
  side_t            d_sd  [0:DIV_STEPS];

  vn_div_lane u_div_x (.clk(clk), .en(en), .mag(r_mx[SQ_STEPS]),
                       .len(r_root[SQ_STEPS]), .quo(qx));
  vn_div_lane u_div_y (.clk(clk), .en(en), .mag(r_my[SQ_STEPS]),
                       .len(r_root[SQ_STEPS]), .quo(qy));
  vn_div_lane u_div_z (.clk(clk), .en(en), .mag(r_mz[SQ_STEPS]),
                       .len(r_root[SQ_STEPS]), .quo(qz));

  assign d_v[0]   = r_v[SQ_STEPS];
  assign d_len[0] = r_root[SQ_STEPS];
  assign d_sd[0]  = r_sd[SQ_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[k+1] <= 1'b0;
      end else if (en) begin
        d_v[k+1] <= d_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_len[k+1] <= d_len[k];
        d_sd[k+1]  <= d_sd[k];
      end
    end
  end

  // ---- output: clamp, sign, pass-through select ----
  localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << FRAC_BITS;

  side_t            fs;
  logic [LEN_W-1:0] flen;
  logic             short_vec;
  logic [QUO_W-1:0] cqx, cqy, cqz;
  logic [OUT_W-1:0] ux, uy, uz;
  logic [OUT_W-1:0] ox, oy, oz;

  assign fs        = d_sd[DIV_STEPS];
  assign flen      = d_len[DIV_STEPS];
  assign short_vec = flen <= LEN_W'(min_length);

  assign cqx = (qx > ONE) ? ONE : qx;
  assign cqy = (qy > ONE) ? ONE : qy;
  assign cqz = (qz > ONE) ? ONE : qz;
  assign ux  = fs.sx ? (OUT_W'(0) - OUT_W'(cqx)) : OUT_W'(cqx);
  assign uy  = fs.sy ? (OUT_W'(0) - OUT_W'(cqy)) : OUT_W'(cqy);
  assign uz  = fs.sz ? (OUT_W'(0) - OUT_W'(cqz)) : OUT_W'(cqz);

  always_comb begin
    ox = short_vec ? fs.rx : ux;
    oy = short_vec ? fs.ry : uy;
    oz = fs.two_d ? '0 : (short_vec ? fs.rz : uz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {2'b00, flen, oz, oy, ox};
      m_tuser <= short_vec;
    end
  end

`ifndef SYNTHESIS
  // a normalized result always has a nonzero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[3*OUT_W+LEN_W-1:3*OUT_W] != '0)
    else $error("normalized beat with zero length");

  // a stalled output holds every stage, so the input side must stall too
  a_stall_ties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // a normalized x component stays within +/- 1.0
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[OUT_W-1:OUT_W-2] == 2'b00) ||
      (m_tdata[OUT_W-1:OUT_W-2] == 2'b11) || (m_tdata[OUT_W-1:0] == OUT_W'(ONE)))
    else $error("unit x out of range");
`endif

endmodule

@@ sim/tb_vector_normalize_unit.sv @@
// Testbench for the vector normalize unit: random and directed vectors, scoreboard check.
`timescale 1ns / 1ps

module tb_vector_normalize_unit;
  import vn_pkg::*;

  // one result beat as the block returns it
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic [LEN_W-1:0] len;
    logic             short_flag;
  } norm_result_t;

  // Scoreboard: predicts the normalized vector for every accepted beat and
  // compares result beats in order.
  class norm_scoreboard;
    norm_result_t pending[$];
    logic [MIN_W-1:0] min_len;
    int errors;

    function new();
      min_len = '0;
      errors  = 0;
    endfunction

    static function logic [31:0] magnitude(logic [31:0] c);
      return c[31] ? (~c + 32'd1) : c;
    endfunction

    static function logic [31:0] floor_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitpos;
      root   = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > n) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
        if (n >= root + bitpos) begin
          n    = n - (root + bitpos);
          root = (root >> 1) + bitpos;
        end else begin
          root = root >> 1;
        end
        bitpos = bitpos >> 2;
      end
      return root[31:0];
    endfunction

    static function logic [OUT_W-1:0] unit_part(logic [31:0] c, logic [31:0] len);
      logic [63:0] q;
      logic [63:0] one;
      one = 64'd1 << FRAC_BITS;
      q   = ({32'd0, magnitude(c)} << FRAC_BITS) / {32'd0, len};
      if (q > one) q = one;
      if (c[31]) q = -q;
      return q[OUT_W-1:0];
    endfunction

    function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic two_d);
      norm_result_t r;
      logic [63:0] sum;
      logic [31:0] mx, my, mz;
      mx  = magnitude(x);
      my  = magnitude(y);
      mz  = magnitude(z);
      sum = {32'd0, mx} * {32'd0, mx} + {32'd0, my} * {32'd0, my};
      if (!two_d) sum = sum + {32'd0, mz} * {32'd0, mz};
      r.len = floor_root(sum);
      if ({32'd0, r.len} <= {47'd0, min_len}) begin
        r.x = x[OUT_W-1:0];
        r.y = y[OUT_W-1:0];
        r.z = two_d ? '0 : z[OUT_W-1:0];
        r.short_flag = 1'b1;
      end else begin
        r.x = unit_part(x, r.len);
        r.y = unit_part(y, r.len);
        r.z = two_d ? '0 : unit_part(z, r.len);
        r.short_flag = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(norm_result_t got);
      norm_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result beat: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.x !== exp_r.x) begin
        $error("x_out: expected %h actual %h", exp_r.x, got.x); errors++;
      end
      if (got.y !== exp_r.y) begin
        $error("y_out: expected %h actual %h", exp_r.y, got.y); errors++;
      end
      if (got.z !== exp_r.z) begin
        $error("z_out: expected %h actual %h", exp_r.z, got.z); errors++;
      end
      if (got.len !== exp_r.len) begin
        $error("vec_length: expected %h actual %h", exp_r.len, got.len); errors++;
      end
      if (got.short_flag !== exp_r.short_flag) begin
        $error("too_short: expected %b actual %b", exp_r.short_flag, got.short_flag);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 53;
  localparam int M_W = 3*OUT_W+LEN_W+2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [3*COMP_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MIN_W-1:0] cfg_data = '0;

  norm_scoreboard board = new();
  bit sink_hold = 0;   // sender asks the receiver to hold off for a long stretch
  bit stim_done = 0;

  always #1 clk = ~clk;

  vector_normalize_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Note every accepted vector and check every accepted result beat.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      board.note_vector(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tuser);
    if (!rst && m_tvalid && m_tready)
      board.check_result({m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W],
                          m_tdata[3*OUT_W-1:2*OUT_W], m_tdata[3*OUT_W+LEN_W-1:3*OUT_W],
                          m_tuser});
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int wait_cycles;
    @(posedge clk iff !rst);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (150) @(posedge clk);
        sink_hold = 0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Offer one vector, hold it until accepted.
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic two_d, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= two_d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_and_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Write min_length while nothing is in flight.
  task automatic write_min_length(logic [MIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.min_len = value;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 131072) - 65536;       // near unit range
      2: return $urandom_range(0, 262144) - 131072;      // short vectors possible
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int count, bit burst);
    int mode, gap;
    repeat (count) begin
      mode = $urandom_range(0, 3);
      gap  = burst ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode),
                  1'($urandom_range(0, 1)), gap);
    end
  endtask

  initial begin
    logic [31:0] dir_vals [8];
    dir_vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h0003_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero vector, 2D and 3D, min_length at reset value 0
    for (int i = 0; i < 8; i++)
      send_vector(dir_vals[i], dir_vals[(i + 3) % 8], dir_vals[(i + 5) % 8], i[0], 0);
    send_vector(32'h0, 32'h0, 32'h0, 1'b0, 0);
    send_vector(32'h0, 32'h0, 32'h8000_0000, 1'b1, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1);
    // length exactly at and just above the threshold once it is raised
    drain_and_idle();
    write_min_length(17'h1_0000);
    send_vector(32'h0001_0000, 32'h0, 32'h0, 1'b0, 0);
    send_vector(32'h0001_0001, 32'h0, 32'h0, 1'b0, 0);
    send_vector(32'hFFFF_0000, 32'h0, 32'h1234_5678, 1'b1, 2);
    send_vector(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 1'b0, 0);
    drain_and_idle();
    write_min_length(17'h1_FFFF);   // above the nominal range
    send_vector(32'h0001_FFFF, 32'h0, 32'h0, 1'b1, 0);
    send_vector(32'h0002_0000, 32'h0, 32'h0, 1'b1, 0);
    send_vector(32'hFFFE_0001, 32'h0, 32'h0001_0000, 1'b0, 0);

    // random phases over several thresholds
    random_phase(250, 0);
    drain_and_idle();
    write_min_length(17'h0);
    random_phase(250, 0);
    // long receiver hold-off while the sender keeps pushing
    sink_hold = 1;
    random_phase(150, 1);
    drain_and_idle();
    write_min_length(17'($urandom_range(1, 65535)));
    random_phase(250, 0);
    drain_and_idle();
    write_min_length(17'h1_0000);
    random_phase(280, 0);
    drain_and_idle();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (board.errors == 0)
      $display("** vector_normalize_unit: PASSED **");
    else
      $display("** vector_normalize_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** vector_normalize_unit: FAILED **");
    $finish;
  end

endmodule
